// ===== src/bmpd_pkg.sv =====
// Shared constants and types for the BMP stream pixel decoder.
// No dependencies; compiled first.
package bmpd_pkg;

  localparam int unsigned MAX_DIM = 16384;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COORD_W  = 14;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned POS_W    = 32;

  localparam logic [15:0] BM_SIGNATURE = 16'h4D42;
  localparam logic [15:0] DEPTH_24     = 16'd24;
  localparam logic [15:0] DEPTH_32     = 16'd32;
  localparam logic [31:0] HEADERS_LEN  = 32'd54;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  // Byte positions at which header fields complete
  localparam logic [POS_W-1:0] POS_SIGNATURE = 32'd1;
  localparam logic [POS_W-1:0] POS_OFFSET    = 32'd13;
  localparam logic [POS_W-1:0] POS_WIDTH     = 32'd21;
  localparam logic [POS_W-1:0] POS_HEIGHT    = 32'd25;
  localparam logic [POS_W-1:0] POS_BITCOUNT  = 32'd29;
  localparam logic [POS_W-1:0] POS_COMPRESS  = 32'd33;
  localparam logic [POS_W-1:0] POS_HDR_LAST  = 32'd53;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_HDR_OK       = 3'd0;
  localparam status_t ST_PIXEL        = 3'd1;
  localparam status_t ST_BAD_SIG      = 3'd2;
  localparam status_t ST_COMPRESSED   = 3'd3;
  localparam status_t ST_BAD_DEPTH    = 3'd4;
  localparam status_t ST_OFFSET_SMALL = 3'd5;
  localparam status_t ST_TOO_LARGE    = 3'd6;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_t;

endpackage

// ===== src/bmpd_if.sv =====
// Handshake channel interfaces for the BMP stream pixel decoder.
// Depends on bmpd_pkg for field widths.
interface bmpd_in_if import bmpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface bmpd_out_if import bmpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]  red;
  logic [BYTE_W-1:0]  green;
  logic [BYTE_W-1:0]  blue;
  logic [BYTE_W-1:0]  alpha;
  logic [COORD_W-1:0] pix_x;
  logic [COORD_W-1:0] pix_y;
  logic               last_pixel;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;

  modport source (output valid, status, red, green, blue, alpha, pix_x, pix_y,
                  last_pixel, image_width, image_height, input ready);
  modport sink   (input valid, status, red, green, blue, alpha, pix_x, pix_y,
                  last_pixel, image_width, image_height, output ready);
endinterface

interface bmpd_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/bmp_stream_pixel_decoder.sv =====
// BMP stream pixel decoder: header parse, skip to pixel data, RGBA output.
// Depends on bmpd_pkg and the channel interfaces in bmpd_if.sv.
//
// An accepted byte's result is registered in the output register, and all parse
// state updates on that byte. One byte per cycle unless the output stalls.
// Reset (rst, synchronous): parser back to header phase, output empty,
// black_transparent set to 1. Config writes are always taken (ready tied high).
module bmp_stream_pixel_decoder import bmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bmpd_cfg_if.sink   cfg,
  bmpd_in_if.sink    in_bytes,
  bmpd_out_if.source results
);

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [31:0]       header_shift, header_shift_next;
  logic [31:0]       data_offset, data_offset_next;
  logic [DIM_W-1:0]  width_reg, width_reg_next;
  logic [DIM_W-1:0]  height_reg, height_reg_next;
  logic              four_bytes_mode, four_bytes_mode_next;
  logic [23:0]       pixel_bytes, pixel_bytes_next;
  logic [1:0]        byte_in_pixel, byte_in_pixel_next;
  logic [COORD_W-1:0] column_count, column_count_next;
  logic [COORD_W-1:0] row_count, row_count_next;
  logic [1:0]        pad_count, pad_count_next;
  logic              depth_bad, depth_bad_next;
  logic              too_large, too_large_next;
  logic              black_transparent;

  // Output register
  logic               out_valid;
  status_t            out_status;
  logic [BYTE_W-1:0]  out_red, out_green, out_blue, out_alpha;
  logic [COORD_W-1:0] out_pix_x, out_pix_y;
  logic               out_last;
  logic [DIM_W-1:0]   out_width, out_height;

  // Result of the byte being accepted
  logic               res_valid;
  status_t            res_status;
  logic [BYTE_W-1:0]  res_red, res_green, res_blue, res_alpha;
  logic               res_last;
  logic [DIM_W-1:0]   res_width, res_height;

  // ---------------------------------------------------------------------------
  // Handshake: a byte may enter whenever the output register is empty or
  // is being drained in the same cycle.
  // ---------------------------------------------------------------------------
  logic in_fire;
  assign in_bytes.ready = !out_valid || results.ready;
  assign in_fire        = in_bytes.valid && in_bytes.ready;
  assign cfg.ready      = 1'b1;

  // ---------------------------------------------------------------------------
  // Restart view: first_byte makes this byte see freshly cleared state.
  // ---------------------------------------------------------------------------
  logic               first;
  logic [BYTE_W-1:0]  d;
  phase_t             ph;
  logic [POS_W-1:0]   pos;
  logic [31:0]        hs_shift, do_base;
  logic [DIM_W-1:0]   w_base, h_base;
  logic               four_base, depth_bad_base, too_large_base;
  logic [23:0]        pb_base;
  logic [1:0]         bip_base, pad_base;
  logic [COORD_W-1:0] col_base, row_base;

  assign first          = in_bytes.first_byte;
  assign d              = in_bytes.data_byte;
  assign ph             = first ? PH_HEADER : phase;
  assign pos            = first ? '0 : byte_position;
  assign hs_shift       = {d, (first ? 24'd0 : header_shift[31:8])};
  assign do_base        = first ? '0 : data_offset;
  assign w_base         = first ? '0 : width_reg;
  assign h_base         = first ? '0 : height_reg;
  assign four_base      = first ? 1'b0 : four_bytes_mode;
  assign depth_bad_base = first ? 1'b0 : depth_bad;
  assign too_large_base = first ? 1'b0 : too_large;
  assign pb_base        = first ? '0 : pixel_bytes;
  assign bip_base       = first ? '0 : byte_in_pixel;
  assign pad_base       = first ? '0 : pad_count;
  assign col_base       = first ? '0 : column_count;
  assign row_base       = first ? '0 : row_count;

  // ---------------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------------
  logic          sig_bad;
  logic          dim_positive, dim_big;
  logic [15:0]   bit_count;
  status_t       hdr_status;
  logic [1:0]    last_bip;
  logic          pix_final;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic          row_end, last_pix;
  logic [1:0]    pad_load, pad_dec;
  logic [POS_W-1:0] pos_inc;
  logic          skip_done;

  assign sig_bad      = hs_shift[31:16] != BM_SIGNATURE;
  assign dim_positive = !hs_shift[31] && (hs_shift != 32'd0);
  assign dim_big      = hs_shift > 32'(MAX_DIM);
  assign bit_count    = hs_shift[31:16];

  // Checks in priority order: compression, depth, offset, size
  always_comb begin
    if (hs_shift != 32'd0) begin
      hdr_status = ST_COMPRESSED;
    end else if (depth_bad_base) begin
      hdr_status = ST_BAD_DEPTH;
    end else if (do_base < HEADERS_LEN) begin
      hdr_status = ST_OFFSET_SMALL;
    end else if (too_large_base) begin
      hdr_status = ST_TOO_LARGE;
    end else begin
      hdr_status = ST_HDR_OK;
    end
  end

  assign last_bip  = four_base ? 2'd3 : 2'd2;
  assign pix_final = !(bip_base < last_bip);
  assign col_inc   = {1'b0, col_base} + 1'b1;
  assign row_inc   = {1'b0, row_base} + 1'b1;
  assign row_end   = col_inc >= w_base;
  assign last_pix  = row_end && (row_inc >= h_base);
  assign pad_load  = four_base ? 2'd0 : w_base[1:0];
  assign pad_dec   = pad_base - 2'd1;
  // Counter saturates; the wrapping +1 here matches the skip compare
  assign pos_inc   = pos + 1'b1;
  assign skip_done = pos_inc >= do_base;

  // ---------------------------------------------------------------------------
  // Next phase
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next = ph;
    case (ph)
      PH_HEADER: begin
        if (pos == POS_SIGNATURE && sig_bad) begin
          phase_next = PH_DONE;
        end else if (pos == POS_COMPRESS && hdr_status != ST_HDR_OK) begin
          phase_next = PH_DONE;
        end else if (pos == POS_HDR_LAST) begin
          if (w_base == '0 || h_base == '0) begin
            phase_next = PH_DONE;
          end else if (do_base <= HEADERS_LEN) begin
            phase_next = PH_PIXEL;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (skip_done) phase_next = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (pix_final) begin
          if (last_pix) begin
            phase_next = PH_DONE;
          end else if (row_end && pad_load != 2'd0) begin
            phase_next = PH_PAD;
          end
        end
      end
      PH_PAD: begin
        if (pad_dec == 2'd0) phase_next = PH_PIXEL;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_position_next   = (pos == '1) ? pos : pos_inc;
    header_shift_next    = first ? '0 : header_shift;
    data_offset_next     = do_base;
    width_reg_next       = w_base;
    height_reg_next      = h_base;
    four_bytes_mode_next = four_base;
    depth_bad_next       = depth_bad_base;
    too_large_next       = too_large_base;
    pixel_bytes_next     = pb_base;
    byte_in_pixel_next   = bip_base;
    column_count_next    = col_base;
    row_count_next       = row_base;
    pad_count_next       = pad_base;

    res_valid  = 1'b0;
    res_status = ST_HDR_OK;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_alpha  = '0;
    res_last   = 1'b0;
    res_width  = '0;
    res_height = '0;

    case (ph)
      PH_HEADER: begin
        header_shift_next = hs_shift;
        if (pos == POS_SIGNATURE) begin
          if (sig_bad) begin
            res_valid  = 1'b1;
            res_status = ST_BAD_SIG;
          end
        end else if (pos == POS_OFFSET) begin
          data_offset_next = hs_shift;
        end else if (pos == POS_WIDTH || pos == POS_HEIGHT) begin
          // Non-positive or oversized reads as zero
          if (dim_positive && dim_big) too_large_next = 1'b1;
          if (pos == POS_WIDTH) begin
            width_reg_next = (dim_positive && !dim_big) ? hs_shift[DIM_W-1:0] : '0;
          end else begin
            height_reg_next = (dim_positive && !dim_big) ? hs_shift[DIM_W-1:0] : '0;
          end
        end else if (pos == POS_BITCOUNT) begin
          four_bytes_mode_next = bit_count == DEPTH_32;
          depth_bad_next       = !(bit_count == DEPTH_24 || bit_count == DEPTH_32);
        end else if (pos == POS_COMPRESS) begin
          res_valid  = 1'b1;
          res_status = hdr_status;
          if (hdr_status == ST_HDR_OK) begin
            res_width  = w_base;
            res_height = h_base;
          end
        end
      end
      PH_PIXEL: begin
        if (!pix_final) begin
          case (bip_base)
            2'd0:    pixel_bytes_next[7:0]   = pb_base[7:0] | d;
            2'd1:    pixel_bytes_next[15:8]  = pb_base[15:8] | d;
            2'd2:    pixel_bytes_next[23:16] = pb_base[23:16] | d;
            default: pixel_bytes_next        = pb_base;
          endcase
          byte_in_pixel_next = bip_base + 2'd1;
        end else begin
          res_valid  = 1'b1;
          res_status = ST_PIXEL;
          res_blue   = pb_base[7:0];
          res_green  = pb_base[15:8];
          res_last   = last_pix;
          if (four_base) begin
            res_red   = pb_base[23:16];
            res_alpha = d;
          end else begin
            res_red   = d;
            // Pure black may be keyed out in 24-bit images
            res_alpha = (black_transparent && d == '0 && pb_base[15:0] == '0)
                      ? '0 : ALPHA_OPAQUE;
          end
          byte_in_pixel_next = '0;
          pixel_bytes_next   = '0;
          column_count_next  = col_inc[COORD_W-1:0];
          if (!last_pix && row_end) begin
            column_count_next = '0;
            row_count_next    = row_inc[COORD_W-1:0];
            pad_count_next    = pad_load;
          end
        end
      end
      PH_PAD: begin
        pad_count_next = pad_dec;
      end
      PH_SKIP, PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_position     <= '0;
      header_shift      <= '0;
      data_offset       <= '0;
      width_reg         <= '0;
      height_reg        <= '0;
      four_bytes_mode   <= 1'b0;
      pixel_bytes       <= '0;
      byte_in_pixel     <= '0;
      column_count      <= '0;
      row_count         <= '0;
      pad_count         <= '0;
      depth_bad         <= 1'b0;
      too_large         <= 1'b0;
    end else if (in_fire) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      header_shift      <= header_shift_next;
      data_offset       <= data_offset_next;
      width_reg         <= width_reg_next;
      height_reg        <= height_reg_next;
      four_bytes_mode   <= four_bytes_mode_next;
      pixel_bytes       <= pixel_bytes_next;
      byte_in_pixel     <= byte_in_pixel_next;
      column_count      <= column_count_next;
      row_count         <= row_count_next;
      pad_count         <= pad_count_next;
      depth_bad         <= depth_bad_next;
      too_large         <= too_large_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      black_transparent <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      black_transparent <= cfg.data;
    end
  end

  // Output register: a new result replaces one that is leaving this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status <= res_status;
      out_red    <= res_red;
      out_green  <= res_green;
      out_blue   <= res_blue;
      out_alpha  <= res_alpha;
      out_pix_x  <= (res_status == ST_PIXEL) ? col_base : '0;
      out_pix_y  <= (res_status == ST_PIXEL) ? row_base : '0;
      out_last   <= res_last;
      out_width  <= res_width;
      out_height <= res_height;
    end
  end

  assign results.valid        = out_valid;
  assign results.status       = out_status;
  assign results.red          = out_red;
  assign results.green        = out_green;
  assign results.blue         = out_blue;
  assign results.alpha        = out_alpha;
  assign results.pix_x        = out_pix_x;
  assign results.pix_y        = out_pix_y;
  assign results.last_pixel   = out_last;
  assign results.image_width  = out_width;
  assign results.image_height = out_height;

endmodule
